### hdl/hbm_pkg.sv
// Shared types and constants of the heartbeat liveness monitor.
package hbm_pkg;

    localparam int OPC_W   = 2;
    localparam int CHAN_W  = 4;
    localparam int ID_W    = 16;
    localparam int EVT_W   = 2;
    localparam int CNT_W   = 5;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [OPC_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OPC_W-1:0] OP_REGISTER = 2'd1;
    localparam logic [OPC_W-1:0] OP_BEAT     = 2'd2;
    localparam logic [OPC_W-1:0] OP_CHECK    = 2'd3;

    localparam logic [EVT_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EVT_W-1:0] EV_OFFLINE = 2'd1;
    localparam logic [EVT_W-1:0] EV_ONLINE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM   = 1'd1;

    localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd500;
    localparam logic [CFG_W-1:0] ALARM_RST   = 16'd1000;

    typedef struct packed {
        logic load;
        logic exec;
        logic step;
        logic flush;
    } hbm_cmd_t;

    typedef struct packed {
        logic out_free;
        logic step_ok;
        logic last_chan;
    } hbm_sts_t;

endpackage

### hdl/hbm_datapath.sv
// Datapath of the heartbeat liveness monitor: channel state, stamp memories and result registers.
module hbm_datapath
    import hbm_pkg::*;
#(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  hbm_cmd_t             cmd,
    output hbm_sts_t             sts,
    input  logic [OPC_W-1:0]     opcode,
    input  logic [CHAN_W-1:0]    channel,
    input  logic [ID_W-1:0]      dev_id,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [EVT_W-1:0]     event_res,
    output logic [CHAN_W-1:0]    chan_out,
    output logic [ID_W-1:0]      id_out,
    output logic [CNT_W-1:0]     count_online,
    output logic                 last
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHW   = (IDX_W > CHAN_W) ? IDX_W : CHAN_W;
    localparam int CMP_W = 8;

    logic [OPC_W-1:0]     op_reg, op_next;
    logic [CHAN_W-1:0]    ch_reg, ch_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [CHANNELS-1:0]  registered_reg, registered_next;
    logic [CHANNELS-1:0]  online_reg, online_next;
    logic [CFG_W-1:0]     timeout_reg, alarm_reg;
    logic [IDX_W-1:0]     idx_reg, idx_next;

    logic                 pend_valid_reg, pend_valid_next;
    logic [EVT_W-1:0]     pend_ev_reg, pend_ev_next;
    logic [CHAN_W-1:0]    pend_ch_reg, pend_ch_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;
    logic [CNT_W-1:0]     pend_cnt_reg, pend_cnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [EVT_W-1:0]     out_ev_reg, out_ev_next;
    logic [CHAN_W-1:0]    out_ch_reg, out_ch_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic [CNT_W-1:0]     out_cnt_reg, out_cnt_next;
    logic                 out_last_reg, out_last_next;

    logic [TIME_BITS-1:0] alive_mem [CHANNELS];
    logic [TIME_BITS-1:0] alarm_mem [CHANNELS];
    logic [ID_W-1:0]      id_mem [CHANNELS];
    logic [TIME_BITS-1:0] alive_rd_reg, alarm_rd_reg;
    logic [ID_W-1:0]      id_rd_reg;

    logic [IDX_W-1:0]     ch_idx;
    logic                 ch_ok, reg_ok, beat_ok;
    logic                 reg_i, onl_i, stale, due, restamp, rep_off, rep_on, report;
    logic                 out_free, load_out;
    logic                 alive_we, alarm_we, id_we;
    logic [IDX_W-1:0]     alarm_waddr;

    assign cfg_ready = 1'b1;

    assign ch_idx  = IDX_W'(ch_reg);
    assign ch_ok   = CMP_W'(ch_reg) < CMP_W'(CHANNELS);
    assign reg_ok  = (op_reg == OP_REGISTER) && ch_ok && !registered_reg[ch_idx];
    assign beat_ok = (op_reg == OP_BEAT) && ch_ok && registered_reg[ch_idx];

    assign reg_i   = registered_reg[idx_reg];
    assign onl_i   = online_reg[idx_reg];
    assign stale   = (now_reg - alive_rd_reg) > TIME_BITS'(timeout_reg);
    assign due     = (now_reg - alarm_rd_reg) > TIME_BITS'(alarm_reg);
    assign restamp = reg_i && stale && due;
    assign rep_off = restamp && onl_i;
    assign rep_on  = reg_i && !stale && !onl_i;
    assign report  = rep_off || rep_on;

    assign out_free = !out_valid_reg || !out_stall;

    assign sts.out_free  = out_free;
    assign sts.step_ok   = !report || !pend_valid_reg || out_free;
    assign sts.last_chan = (idx_reg == IDX_W'(CHANNELS - 1));

    assign alive_we    = cmd.exec && (reg_ok || beat_ok);
    assign id_we       = cmd.exec && reg_ok;
    assign alarm_we    = (cmd.exec && reg_ok) || (cmd.step && restamp);
    assign alarm_waddr = cmd.step ? idx_reg : ch_idx;

    always_comb
    begin
        op_next         = op_reg;
        ch_next         = ch_reg;
        id_next         = id_reg;
        now_next        = now_reg;
        total_next      = total_reg;
        registered_next = registered_reg;
        online_next     = online_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_ev_next    = pend_ev_reg;
        pend_ch_next    = pend_ch_reg;
        pend_id_next    = pend_id_reg;
        pend_cnt_next   = pend_cnt_reg;
        load_out        = 1'b0;
        out_ev_next     = out_ev_reg;
        out_ch_next     = out_ch_reg;
        out_id_next     = out_id_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;

        if (cmd.load)
        begin
            op_next         = opcode;
            ch_next         = channel;
            id_next         = dev_id;
            idx_next        = '0;
            pend_valid_next = 1'b0;
        end

        if (cmd.exec)
        begin
            case (op_reg)
                OP_TICK:
                begin
                    now_next = now_reg + TIME_BITS'(1);
                end
                OP_REGISTER:
                begin
                    if (reg_ok)
                    begin
                        registered_next[ch_idx] = 1'b1;
                        online_next[ch_idx]     = 1'b0;
                    end
                end
                OP_BEAT:
                begin
                    if (beat_ok && !online_reg[ch_idx])
                    begin
                        online_next[ch_idx] = 1'b1;
                        total_next          = total_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
            load_out      = 1'b1;
            out_ev_next   = EV_NONE;
            out_ch_next   = '0;
            out_id_next   = '0;
            out_cnt_next  = total_next;
            out_last_next = 1'b1;
        end

        if (cmd.step)
        begin
            if (rep_off)
            begin
                online_next[idx_reg] = 1'b0;
                total_next           = total_reg - CNT_W'(1);
            end
            if (report)
            begin
                if (pend_valid_reg)
                begin
                    load_out      = 1'b1;
                    out_ev_next   = pend_ev_reg;
                    out_ch_next   = pend_ch_reg;
                    out_id_next   = pend_id_reg;
                    out_cnt_next  = pend_cnt_reg;
                    out_last_next = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_ev_next    = rep_off ? EV_OFFLINE : EV_ONLINE;
                pend_ch_next    = CHAN_W'(CHW'(idx_reg));
                pend_id_next    = id_rd_reg;
                pend_cnt_next   = total_next;
            end
            idx_next = IDX_W'(idx_reg + IDX_W'(1));
        end

        if (cmd.flush)
        begin
            load_out        = 1'b1;
            pend_valid_next = 1'b0;
            out_last_next   = 1'b1;
            if (pend_valid_reg)
            begin
                out_ev_next  = pend_ev_reg;
                out_ch_next  = pend_ch_reg;
                out_id_next  = pend_id_reg;
                out_cnt_next = pend_cnt_reg;
            end
            else
            begin
                out_ev_next  = EV_NONE;
                out_ch_next  = '0;
                out_id_next  = '0;
                out_cnt_next = total_reg;
            end
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            total_reg      <= '0;
            registered_reg <= '0;
            online_reg     <= '0;
            timeout_reg    <= TIMEOUT_RST;
            alarm_reg      <= ALARM_RST;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            now_reg        <= now_next;
            total_reg      <= total_next;
            registered_reg <= registered_next;
            online_reg     <= online_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_index == CFG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_ALARM)
            begin
                alarm_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ch_reg       <= ch_next;
        id_reg       <= id_next;
        pend_ev_reg  <= pend_ev_next;
        pend_ch_reg  <= pend_ch_next;
        pend_id_reg  <= pend_id_next;
        pend_cnt_reg <= pend_cnt_next;
        out_ev_reg   <= out_ev_next;
        out_ch_reg   <= out_ch_next;
        out_id_reg   <= out_id_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (alive_we)
        begin
            alive_mem[ch_idx] <= now_reg;
        end
        if (alarm_we)
        begin
            alarm_mem[alarm_waddr] <= now_reg;
        end
        if (id_we)
        begin
            id_mem[ch_idx] <= id_reg;
        end
        alive_rd_reg <= alive_mem[idx_next];
        alarm_rd_reg <= alarm_mem[idx_next];
        id_rd_reg    <= id_mem[idx_next];
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = out_ev_reg;
    assign chan_out     = out_ch_reg;
    assign id_out       = out_id_reg;
    assign count_online = out_cnt_reg;
    assign last         = out_last_reg;

endmodule

### hdl/hbm_ctrl.sv
// Controller state machine of the heartbeat liveness monitor.
module hbm_ctrl
    import hbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [OPC_W-1:0] opcode,
    input  hbm_sts_t         sts,
    output hbm_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (opcode == OP_CHECK) ? ST_SWEEP : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (sts.step_ok)
                begin
                    cmd.step = 1'b1;
                    if (sts.last_chan)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

### hdl/heartbeat_liveness_monitor_core.sv
// Top level of the heartbeat liveness monitor.
// Requests enter on in_valid/in_stall with opcode, channel and dev_id: a tick
// advances the millisecond clock, a register request stores a channel, a
// heartbeat restamps it, and a check sweeps every channel in ascending order.
// Results leave on out_valid/out_stall; last marks the final result of a request.
// Configuration writes (timeout and alarm interval) use cfg_valid/cfg_ready and
// are accepted in every cycle; write them only while the block is idle.
// Tick, register and heartbeat requests each give one result, which is loaded
// into the output register once that register is free.
// During a check the stamp memories are read one channel per cycle while the
// output keeps up; one report is held back so the final one can carry last.
// The block takes one request at a time; in_stall is high until it is done.
// A stalled receiver holds the output register and the sweep waits on it.
// Reset clears the channel table, the clock and the online count, and loads
// a timeout of 500 and an alarm interval of 1000 milliseconds.
module heartbeat_liveness_monitor_core
    import hbm_pkg::*;
#(
    parameter int CHANNELS  = 16,
    parameter int TIME_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [OPC_W-1:0]     opcode,
    input  logic [CHAN_W-1:0]    channel,
    input  logic [ID_W-1:0]      dev_id,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [EVT_W-1:0]     event_res,
    output logic [CHAN_W-1:0]    chan_out,
    output logic [ID_W-1:0]      id_out,
    output logic [CNT_W-1:0]     count_online,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    hbm_cmd_t cmd;
    hbm_sts_t sts;

    hbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .sts      (sts),
        .cmd      (cmd)
    );

    hbm_datapath #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .channel      (channel),
        .dev_id       (dev_id),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .chan_out     (chan_out),
        .id_out       (id_out),
        .count_online (count_online),
        .last         (last)
    );

endmodule

### dv/heartbeat_liveness_monitor_core_tb.sv
// Self-checking testbench of the heartbeat liveness monitor with random stimulus and stalls.
`timescale 1ns / 1ps

module heartbeat_liveness_monitor_core_tb
    import hbm_pkg::*;
();

    localparam int NUM_CHANNELS   = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;

    typedef struct packed {
        logic [EVT_W-1:0]  evt;
        logic [CHAN_W-1:0] chan;
        logic [ID_W-1:0]   id;
        logic [CNT_W-1:0]  count;
        logic              last;
    } monitor_event_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [OPC_W-1:0]     opcode;
    logic [CHAN_W-1:0]    channel;
    logic [ID_W-1:0]      dev_id;
    logic                 out_valid;
    logic                 out_stall;
    logic [EVT_W-1:0]     event_res;
    logic [CHAN_W-1:0]    chan_out;
    logic [ID_W-1:0]      id_out;
    logic [CNT_W-1:0]     count_online;
    logic                 last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    monitor_event_t pending_events[$];
    int             mismatch_count;
    int             hold_cycles;
    bit             idle_on;

    logic [CFG_W-1:0]  mon_timeout;
    logic [CFG_W-1:0]  mon_alarm;
    logic              mon_known[NUM_CHANNELS];
    logic              mon_live[NUM_CHANNELS];
    logic [31:0]       mon_seen[NUM_CHANNELS];
    logic [31:0]       mon_alarm_at[NUM_CHANNELS];
    logic [ID_W-1:0]   mon_dev[NUM_CHANNELS];
    logic [31:0]       mon_now;
    logic [CNT_W-1:0]  mon_online;

    heartbeat_liveness_monitor_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .channel      (channel),
        .dev_id       (dev_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .chan_out     (chan_out),
        .id_out       (id_out),
        .count_online (count_online),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic void compute_events(input logic [OPC_W-1:0] op,
                                           input logic [CHAN_W-1:0] ch,
                                           input logic [ID_W-1:0] id);
        monitor_event_t found[$];
        monitor_event_t ev;
        logic [31:0]    since_beat;
        logic [31:0]    since_alarm;
        case (op)
            OP_TICK:
            begin
                mon_now = mon_now + 32'd1;
            end
            OP_REGISTER:
            begin
                if (!mon_known[ch])
                begin
                    mon_known[ch]    = 1'b1;
                    mon_live[ch]     = 1'b0;
                    mon_seen[ch]     = mon_now;
                    mon_alarm_at[ch] = mon_now;
                    mon_dev[ch]      = id;
                end
            end
            OP_BEAT:
            begin
                if (mon_known[ch])
                begin
                    mon_seen[ch] = mon_now;
                    if (!mon_live[ch])
                    begin
                        mon_live[ch] = 1'b1;
                        mon_online   = mon_online + 5'd1;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    if (mon_known[i])
                    begin
                        since_beat  = mon_now - mon_seen[i];
                        since_alarm = mon_now - mon_alarm_at[i];
                        if (since_beat > {16'd0, mon_timeout})
                        begin
                            if (since_alarm > {16'd0, mon_alarm})
                            begin
                                if (mon_live[i])
                                begin
                                    mon_live[i] = 1'b0;
                                    mon_online  = mon_online - 5'd1;
                                    ev = '{EV_OFFLINE, CHAN_W'(i), mon_dev[i], mon_online, 1'b0};
                                    found.push_back(ev);
                                end
                                mon_alarm_at[i] = mon_now;
                            end
                        end
                        else if (!mon_live[i])
                        begin
                            ev = '{EV_ONLINE, CHAN_W'(i), mon_dev[i], mon_online, 1'b0};
                            found.push_back(ev);
                        end
                    end
                end
            end
        endcase
        if (found.size() == 0)
        begin
            ev = '{EV_NONE, '0, '0, mon_online, 1'b0};
            found.push_back(ev);
        end
        found[found.size()-1].last = 1'b1;
        foreach (found[k])
        begin
            pending_events.push_back(found[k]);
        end
    endfunction

    task automatic send_request(input logic [OPC_W-1:0] op, input logic [CHAN_W-1:0] ch,
                                input logic [ID_W-1:0] id);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode   = op;
        channel  = ch;
        dev_id   = id;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        compute_events(op, ch, id);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_events.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_TIMEOUT)
            mon_timeout = data;
        else
            mon_alarm = data;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_intervals(input logic [CFG_W-1:0] timeout, input logic [CFG_W-1:0] alarm);
        wait_idle();
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_ALARM, alarm);
    endtask

    function automatic logic [CHAN_W-1:0] pick_known_channel();
        logic [CHAN_W-1:0] ch;
        ch = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
        for (int tries = 0; tries < 16 && !mon_known[ch]; tries++)
        begin
            ch = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
        end
        return ch;
    endfunction

    task automatic send_random_request();
        int                r;
        logic [CHAN_W-1:0] ch;
        r  = $urandom_range(0, 99);
        ch = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
        if (r < 40)
            send_request(OP_TICK, ch, ID_W'($urandom));
        else if (r < 48)
            send_request(OP_REGISTER, ch, ID_W'($urandom));
        else if (r < 73)
            send_request(OP_BEAT, ($urandom_range(0, 4) == 0) ? ch : pick_known_channel(),
                         ID_W'($urandom));
        else
            send_request(OP_CHECK, ch, ID_W'($urandom));
    endtask

    // Reset intervals: registration, fresh channels reported online, ignored requests.
    task automatic test_reset_intervals();
        send_request(OP_TICK, 4'd0, 16'h0000);
        send_request(OP_CHECK, 4'd0, 16'h0000);
        send_request(OP_BEAT, 4'd3, 16'h1234);
        send_request(OP_REGISTER, 4'd0, 16'h0000);
        send_request(OP_REGISTER, 4'd15, 16'hFFFF);
        send_request(OP_CHECK, 4'd15, 16'hFFFF);
        send_request(OP_BEAT, 4'd15, 16'h0000);
        send_request(OP_REGISTER, 4'd15, 16'h5A5A);
        send_request(OP_CHECK, 4'd0, 16'h0000);
    endtask

    // Short intervals: online channels go offline, then the alarm interval rate-limits.
    task automatic test_stale_offline();
        set_intervals(16'd1, 16'd1);
        send_request(OP_REGISTER, 4'd5, 16'hA5C3);
        send_request(OP_BEAT, 4'd5, 16'h0000);
        send_request(OP_BEAT, 4'd0, 16'h0000);
        repeat (3) send_request(OP_TICK, 4'd0, 16'h0000);
        send_request(OP_CHECK, 4'd0, 16'h0000);
        send_request(OP_CHECK, 4'd0, 16'h0000);
        repeat (2) send_request(OP_TICK, 4'd0, 16'h0000);
        send_request(OP_CHECK, 4'd0, 16'h0000);
    endtask

    // Zero intervals are taken literally: any elapsed time makes a channel stale.
    task automatic test_zero_intervals();
        set_intervals(16'd0, 16'd0);
        send_request(OP_BEAT, 4'd5, 16'h0000);
        send_request(OP_CHECK, 4'd5, 16'h0000);
        send_request(OP_TICK, 4'd0, 16'h0000);
        send_request(OP_CHECK, 4'd0, 16'h0000);
    endtask

    task automatic test_max_intervals();
        set_intervals(16'hFFFF, 16'hFFFF);
        send_request(OP_CHECK, 4'd0, 16'h0000);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            set_intervals(CFG_W'($urandom_range(0, 10)), CFG_W'($urandom_range(0, 16)));
            idle_on = (phase != 1);
            repeat (55) send_random_request();
        end
        idle_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        set_intervals(16'd3, 16'd2);
        idle_on     = 1'b0;
        hold_cycles = HOLD_CYCLES;
        repeat (24) send_random_request();
        idle_on = 1'b1;
    endtask

    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            n = idle_on ? $urandom_range(0, 14) : 0;
            out_stall = (n > 0);
            if (n > 0)
            begin
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    initial
    begin
        monitor_event_t got;
        monitor_event_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got = '{event_res, chan_out, id_out, count_online, last};
                if (pending_events.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: evt %0d chan %0d id %h count %0d last %0b",
                                 got.evt, got.chan, got.id, got.count, got.last);
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (got.evt !== want.evt || got.chan !== want.chan || got.id !== want.id
                        || got.count !== want.count || got.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch at %0t: expected evt %0d chan %0d id %h cnt %0d last %0b",
                                     $realtime, want.evt, want.chan, want.id, want.count,
                                     want.last);
                            $display("    got evt %0d chan %0d id %h cnt %0d last %0b",
                                     got.evt, got.chan, got.id, got.count, got.last);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_TICK;
        channel        = '0;
        dev_id         = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_TIMEOUT;
        cfg_data       = '0;
        mismatch_count = 0;
        hold_cycles    = 0;
        idle_on        = 1'b1;
        mon_timeout    = TIMEOUT_RST;
        mon_alarm      = ALARM_RST;
        mon_now        = '0;
        mon_online     = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            mon_known[i]    = 1'b0;
            mon_live[i]     = 1'b0;
            mon_seen[i]     = '0;
            mon_alarm_at[i] = '0;
            mon_dev[i]      = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_intervals();
        test_stale_offline();
        test_zero_intervals();
        test_max_intervals();
        test_random_traffic();
        test_backpressure();

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_events.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
